// ===== hw/rtl/ffba_pkg.sv =====
// shared constants and helpers for the first-fit block allocator
// no dependencies
package ffba_pkg;
  localparam int unsigned PoolBlocksDef = 1024;
  localparam int unsigned MaxRunsDef    = 512;
  localparam int unsigned PoolsDef      = 2;
  localparam int unsigned DepthShift    = 8;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // block table entry [size_class][shape], shape saturates at tall
  function automatic logic [12:0] table_lookup(input logic [1:0] size_class,
                                               input logic [1:0] shape);
    logic [1:0] sh;
    logic [12:0] v;
    sh = (shape > 2'd2) ? 2'd2 : shape;
    v = '0;
    case (size_class)
      2'd0: v = (sh == 2'd0) ? 13'd64 : 13'd128;
      2'd1: v = 13'd256;
      2'd2: v = (sh == 2'd0) ? 13'd1024 : 13'd512;
      2'd3: v = (sh == 2'd0) ? 13'd4096 : 13'd2048;
      default: v = '0;
    endcase
    return v;
  endfunction

  // blocks needed for an allocate, at least one
  function automatic logic [5:0] blocks_needed(input logic [1:0] size_class,
                                               input logic [1:0] shape,
                                               input logic color_depth);
    logic [12:0] t;
    logic [12:0] n;
    t = table_lookup(size_class, shape);
    n = color_depth ? (t >> (DepthShift - 1)) : (t >> DepthShift);
    if (n == '0) n = 13'd1;
    return n[5:0];
  endfunction
endpackage

// ===== hw/rtl/ffba_ram.sv =====
// single-port synchronous memory with a registered read
// no dependencies
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// first-fit block allocator top level: sequencer over run list and region memories
// depends on ffba_pkg and ffba_ram
//
// usage: requests arrive on the s_axis group (tvalid/tready/tdata), one
// result per request leaves on the m_axis group. the user must write handle_base
// on the cfg channel only while the block is idle; the block does not enforce it.
// each pool keeps an address-ordered list of free runs (start, length) in a
// run memory, and the size of each allocated region in a region memory.
// an allocate reads and compares one run at a time (S_ARD, S_ACMP) until one
// fits, then shifts the tail down entry by entry (S_DRD, S_DWR) if the run empties.
// a free scans run by run (S_FREG, S_FCMP) for its insertion point, then shifts
// entries up (S_URD, S_UWR) or down (S_DRD, S_DWR) entry by entry.
// every run access goes through the single run memory port; one request is
// in flight at a time.
// after reset a clearing pass walks every entry of the region memory and
// sets up run 0 of each pool; no request is taken meanwhile.
// the result sits in an output register; the next request is taken only once
// it has been delivered, so a stalled receiver holds the block.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned POOL_BLOCKS = PoolBlocksDef,
  parameter int unsigned MAX_RUNS    = MaxRunsDef,
  parameter int unsigned POOLS       = PoolsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation, pool, shape[1:0], size_class[1:0], color_depth, handle_in[10:0]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, handle_out[10:0], block_count[5:0]
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i
);
  localparam int unsigned PW  = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int unsigned BW  = $clog2(POOL_BLOCKS);     // block index
  localparam int unsigned LW  = BW + 1;                  // run length
  localparam int unsigned RW  = $clog2(MAX_RUNS);        // run index
  localparam int unsigned CW  = RW + 1;                  // run count
  localparam int unsigned RAW = PW + RW;
  localparam int unsigned GAW = PW + BW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ARD, S_ACMP, S_FRD, S_FREG, S_FCMP,
    S_DRD, S_DWR, S_URD, S_UWR, S_FIN, S_OUT
  } state_e;

  state_e        state_q;
  logic [GAW:0]  clr_q;
  logic [9:0]    base_q;
  logic [CW-1:0] cnt_q [POOLS];

  // captured request
  logic [PW-1:0] pool_q;
  logic [5:0]    need_q;
  logic [BW-1:0] off_q;
  logic [LW-1:0] len_q;
  logic [CW-1:0] i_q;      // scan index / shift index
  logic [CW-1:0] stop_q;   // shift bound
  logic [BW-1:0] pend_s_q; // prev run start/len seen during free scan
  logic [LW-1:0] pend_l_q;
  logic          prev_adj_q;

  logic          st_q;
  logic [10:0]   ho_q;
  logic [5:0]    bc_q;

  // run memory: {start, length}
  logic          rwe;
  logic [RAW-1:0] raddr;
  logic [BW+LW-1:0] rwdata, rrdata;
  logic [BW-1:0] rd_s;
  logic [LW-1:0] rd_l;
  // region memory
  logic          gwe;
  logic [GAW-1:0] gaddr;
  logic [5:0]    gwdata, grdata;

  ffba_ram #(.Width(BW + LW), .Depth(POOLS * MAX_RUNS)) u_runs (
    .clk_i, .we_i(rwe), .addr_i(raddr), .wdata_i(rwdata), .rdata_o(rrdata));
  ffba_ram #(.Width(6), .Depth(POOLS * POOL_BLOCKS)) u_regions (
    .clk_i, .we_i(gwe), .addr_i(gaddr), .wdata_i(gwdata), .rdata_o(grdata));

  assign rd_s = rrdata[BW+LW-1:LW];
  assign rd_l = rrdata[LW-1:0];

  logic [CW-1:0] n_cur;
  assign n_cur = cnt_q[pool_q];

  function automatic logic [RAW-1:0] ra(input logic [PW-1:0] p, input logic [CW-1:0] i);
    return {p, i[RW-1:0]};
  endfunction

  // request fields
  logic          in_op, in_pool_bad;
  logic [PW-1:0] in_pool;
  logic [11:0]   in_off;
  assign in_op       = s_axis_tdata[0];
  assign in_pool     = PW'(s_axis_tdata[1]);
  assign in_pool_bad = {31'd0, s_axis_tdata[1]} >= 32'(POOLS);
  assign in_off      = {1'b0, s_axis_tdata[17:7]} - {2'b0, base_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, bc_q, ho_q, st_q};

  // adjacency of the freed blocks to the next run, and merged run length
  logic          next_adj;
  logic [LW:0]   merged;
  assign next_adj = (i_q < n_cur) && ({1'b0, off_q} + len_q == {1'b0, rd_s});

  // memory address/write control
  always_comb begin
    rwe = 1'b0; raddr = ra(pool_q, i_q); rwdata = '0;
    gwe = 1'b0; gaddr = {pool_q, off_q}; gwdata = '0;
    merged = '0;
    case (state_q)
      S_CLEAR: begin
        gwe = 1'b1; gaddr = clr_q[GAW-1:0];
        if (clr_q[BW-1:0] == '0) begin
          rwe = 1'b1; raddr = {clr_q[GAW-1:BW], {RW{1'b0}}};
          rwdata = {{BW{1'b0}}, LW'(POOL_BLOCKS)};
        end
      end
      S_IDLE: begin
        gaddr = {in_pool, in_off[BW-1:0]};
      end
      S_ACMP: begin
        if (rd_l >= LW'(need_q) && i_q < n_cur) begin
          gwe = 1'b1; gaddr = {pool_q, rd_s}; gwdata = need_q;
          if (rd_l != LW'(need_q)) begin
            rwe = 1'b1;
            rwdata = {rd_s + BW'(need_q), rd_l - LW'(need_q)};
          end
        end
      end
      S_DRD: raddr = ra(pool_q, i_q + 1'b1);
      S_DWR: begin rwe = 1'b1; rwdata = rrdata; end
      S_URD: raddr = ra(pool_q, i_q - 1'b1);
      S_UWR: begin rwe = 1'b1; rwdata = rrdata; end
      S_FCMP: begin
        if (!(i_q < n_cur && rd_s <= off_q)) begin
          if (prev_adj_q) begin
            rwe = 1'b1; raddr = ra(pool_q, i_q - 1'b1);
            merged = {1'b0, pend_l_q} + (LW+1)'(len_q) + (next_adj ? {1'b0, rd_l} : '0);
            rwdata = {pend_s_q, merged[LW-1:0]};
          end else if (next_adj) begin
            rwe = 1'b1; rwdata = {off_q, rd_l + len_q};
          end
          gwe = prev_adj_q || next_adj || (n_cur < CW'(MAX_RUNS));
        end
      end
      S_FIN: begin rwe = 1'b1; rwdata = {off_q, len_q}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; base_q <= '0;
      for (int p = 0; p < POOLS; p++) cnt_q[p] <= CW'(1);
      pool_q <= '0; need_q <= '0; off_q <= '0;
      len_q <= '0; i_q <= '0; stop_q <= '0; pend_s_q <= '0; pend_l_q <= '0;
      prev_adj_q <= 1'b0; st_q <= 1'b0; ho_q <= '0; bc_q <= '0;
    end else begin
      if (cfg_valid_i) base_q <= cfg_data_i;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (GAW+1)'(POOLS * POOL_BLOCKS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pool_q <= in_pool; i_q <= '0;
            need_q <= blocks_needed(s_axis_tdata[5:4], s_axis_tdata[3:2], s_axis_tdata[6]);
            off_q <= BW'(({1'b0, s_axis_tdata[17:7]} - {2'b0, base_q}));
            prev_adj_q <= 1'b0;
            if (in_pool_bad) begin
              st_q <= 1'b1; ho_q <= '0; bc_q <= '0; state_q <= S_OUT;
            end else if (in_op == OpAlloc) begin
              state_q <= S_ARD;
            end else if (s_axis_tdata[17:7] < {1'b0, base_q} ||
                         {1'b0, s_axis_tdata[17:7]} - {2'b0, base_q} >= 12'(POOL_BLOCKS)) begin
              st_q <= 1'b0; ho_q <= '0; bc_q <= '0; state_q <= S_OUT;
            end else begin
              state_q <= S_FRD;
            end
          end
        end
        S_ARD: state_q <= S_ACMP;
        S_ACMP: begin
          if (i_q >= n_cur) begin
            st_q <= 1'b1; ho_q <= '0; bc_q <= '0; state_q <= S_OUT;
          end else if (rd_l >= LW'(need_q)) begin
            st_q <= 1'b0; ho_q <= 11'(rd_s) + 11'(base_q); bc_q <= need_q;
            if (rd_l == LW'(need_q)) begin
              cnt_q[pool_q] <= n_cur - 1'b1;
              stop_q <= n_cur - 1'b1;
              state_q <= (i_q + 1'b1 < n_cur) ? S_DRD : S_OUT;
            end else state_q <= S_OUT;
          end else begin
            i_q <= i_q + 1'b1; state_q <= S_ARD;
          end
        end
        S_DRD: state_q <= S_DWR;
        S_DWR: begin
          i_q <= i_q + 1'b1;
          state_q <= (i_q + 1'b1 < stop_q) ? S_DRD : S_OUT;
        end
        S_FRD: state_q <= S_FREG;
        S_FREG: begin
          len_q <= LW'(grdata);
          if (grdata == '0) begin
            st_q <= 1'b0; ho_q <= '0; bc_q <= '0; state_q <= S_OUT;
          end else state_q <= S_FCMP;
        end
        S_FCMP: begin
          if (i_q < n_cur && rd_s <= off_q) begin
            pend_s_q <= rd_s; pend_l_q <= rd_l;
            prev_adj_q <= ({1'b0, rd_s} + rd_l == {1'b0, off_q});
            i_q <= i_q + 1'b1; state_q <= S_FREG;
          end else begin
            st_q <= 1'b0; ho_q <= '0; bc_q <= len_q[5:0];
            if (prev_adj_q && next_adj) begin
              cnt_q[pool_q] <= n_cur - 1'b1; stop_q <= n_cur - 1'b1;
              state_q <= (i_q + 1'b1 < n_cur) ? S_DRD : S_OUT;
            end else if (prev_adj_q || next_adj) begin
              state_q <= S_OUT;
            end else if (n_cur >= CW'(MAX_RUNS)) begin
              st_q <= 1'b1; bc_q <= '0; state_q <= S_OUT;
            end else begin
              cnt_q[pool_q] <= n_cur + 1'b1; stop_q <= i_q; i_q <= n_cur;
              state_q <= (n_cur > i_q) ? S_URD : S_FIN;
            end
          end
        end
        S_URD: state_q <= S_UWR;
        S_UWR: begin
          i_q <= i_q - 1'b1;
          state_q <= (i_q - 1'b1 > stop_q) ? S_URD : S_FIN;
        end
        S_FIN: state_q <= S_OUT;
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // run count of the selected pool never exceeds the list capacity
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[pool_q] <= CW'(MAX_RUNS)) else $error("run count overflow");
  // a result is held until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  // no request taken while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("overlap");
  // no result ever reports more than 32 blocks
  a_bc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> bc_q <= 6'd32) else $error("bad count");
endmodule
